@@ hw/rtl/hwb_pkg.sv @@
// Shared types, coefficient tables and helpers of the Hermite basis evaluator.
package hwb_pkg;

  localparam int NCOEF = 6;
  localparam int CW = 18;
  localparam int AW = 52;

  typedef logic signed [CW-1:0] coef_t;
  typedef coef_t [NCOEF-1:0] coef_row_t;

  typedef struct packed {
    coef_row_t   coef;
    logic [32:0] t;
    logic [6:0]  expo;
    logic        err;
    logic        kill;
  } job_t;

  typedef enum logic [1:0] {
    SIDE_PLAIN = 2'd0,
    SIDE_LEFT  = 2'd1,
    SIDE_RIGHT = 2'd2,
    SIDE_ALT   = 2'd3
  } side_e;

  typedef enum logic {
    REG_POLY_MODE = 1'b0,
    REG_EDGE_EPS  = 1'b1
  } cfg_reg_e;

  // Monomial rows times two, indexed [mode][mesh][basis][power].
  localparam int BASE_POLY [2][2][6][6] = '{
    '{
      '{ '{2, 0, -6, 4, 0, 0}, '{0, 0, 6, -4, 0, 0},
         '{0, 2, -4, 2, 0, 0}, '{0, 0, -2, 2, 0, 0},
         '{0, 0, 0, 0, 0, 0},  '{0, 0, 0, 0, 0, 0} },
      '{ '{0, 0, 24, -32, 0, 0}, '{-8, 48, -72, 32, 0, 0},
         '{0, 0, -4, 8, 0, 0},   '{-4, 16, -20, 8, 0, 0},
         '{0, 0, 0, 0, 0, 0},    '{0, 0, 0, 0, 0, 0} }
    },
    '{
      '{ '{2, 0, 0, -20, 30, -12}, '{0, 0, 0, 20, -30, 12},
         '{0, 2, 0, -12, 16, -6},  '{0, 0, 0, -8, 14, -6},
         '{0, 0, 1, -3, 3, -1},    '{0, 0, 0, 1, -2, 1} },
      '{ '{0, 0, 0, 160, -480, 384}, '{64, -480, 1440, -2080, 1440, -384},
         '{0, 0, 0, -32, 112, -96},  '{16, -128, 384, -544, 368, -96},
         '{0, 0, 0, 2, -8, 8},       '{2, -14, 38, -50, 32, -8} }
    }
  };

  // Coefficient row of the requested derivative; a small constant table in hardware.
  function automatic coef_row_t poly_row(logic mode, logic mesh, logic [2:0] basis,
                                         logic [1:0] d);
    int c [NCOEF];
    int b;
    coef_row_t r;
    b = (basis > 3'd5) ? 0 : int'(basis);
    for (int k = 0; k < NCOEF; k++) c[k] = BASE_POLY[mode][mesh][b][k];
    for (int s = 0; s < 3; s++) begin
      if (s < int'(d)) begin
        for (int k = 0; k < NCOEF - 1; k++) c[k] = (k + 1) * c[k+1];
        c[NCOEF-1] = 0;
      end
    end
    for (int k = 0; k < NCOEF; k++) r[k] = CW'(c[k]);
    return r;
  endfunction

endpackage

@@ hw/rtl/hermite_wavelet_basis_eval.sv @@
// Top level of the Hermite multiresolution basis evaluator.
//
//  channel   direction  width  contents
//  s_axis    in         64     point, level, support index, basis, derivative, side
//  m_axis    out        48     mantissa, scale exponent, error flag
//  cfg       in         16     polynomial mode, edge offset
//
// One request is taken per cycle while the queue is not full; a result passes through the
// queue, a stage that loads the leading coefficient, five Horner steps of a multiply stage
// and an add stage each, and the output register.
// A four-entry queue sits between the front and the back; the front stalls only when it
// is full, and the back pipe holds as a whole while the output register is not taken.
// Reset clears the queue and pipe valid bits and loads mode 0 and edge offset 4.
module hermite_wavelet_basis_eval #(
  parameter int MAX_LEVEL     = 16,
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_pos[32:0], level[37:33], support_index[52:38], degree[55:53],
  // deriv_order[57:56], side[59:58], zeros above
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value[35:0], scale_exp[42:36], error[43], zeros above
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import hwb_pkg::*;

  localparam int QDEPTH = 4;

  logic               mode_q;
  logic [15:0]        eps_q;
  job_t               job_in, job_out;
  logic               push, full, empty, pop;
  logic signed [35:0] value;
  logic signed [6:0]  scale_exp;
  logic               error;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      eps_q  <= 16'd4;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_POLY_MODE: mode_q <= cfg_wdata_i[0];
        REG_EDGE_EPS:  eps_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  hwb_front #(.MAX_LEVEL(MAX_LEVEL)) u_front (
    .x_pos_i        (s_axis_tdata[32:0]),
    .level_i        (s_axis_tdata[37:33]),
    .support_index_i(s_axis_tdata[52:38]),
    .degree_i       (s_axis_tdata[55:53]),
    .deriv_order_i  (s_axis_tdata[57:56]),
    .side_i         (s_axis_tdata[59:58]),
    .poly_mode_i    (mode_q),
    .edge_epsilon_i (eps_q),
    .job_o          (job_in)
  );

  assign s_axis_tready = !full;
  assign push          = s_axis_tvalid && !full;

  hwb_fifo #(.WIDTH($bits(job_t)), .DEPTH(QDEPTH)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(job_in),
    .full_o (full),
    .pop_i  (pop),
    .rdata_o(job_out),
    .empty_o(empty)
  );

  hwb_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job_out),
    .job_valid_i(!empty),
    .job_pop_o  (pop),
    .value_o    (value),
    .scale_exp_o(scale_exp),
    .error_o    (error),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {4'b0, error, scale_exp, value};
endmodule

@@ hw/rtl/hwb_fifo.sv @@
// Small register queue between the classifying front and the evaluation back.
module hwb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (pop_i)  rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end
endmodule

@@ hw/rtl/hwb_front.sv @@
// Front part: checks a request, applies the edge offset and the level map, picks coefficients.
module hwb_front #(
  parameter int MAX_LEVEL = 16
) (
  input  logic          [32:0] x_pos_i,
  input  logic          [4:0]  level_i,
  input  logic          [14:0] support_index_i,
  input  logic          [2:0]  degree_i,
  input  logic          [1:0]  deriv_order_i,
  input  logic          [1:0]  side_i,
  input  logic                 poly_mode_i,
  input  logic          [15:0] edge_epsilon_i,
  output hwb_pkg::job_t        job_o
);
  import hwb_pkg::*;

  localparam int TW = (MAX_LEVEL > 12) ? (36 + MAX_LEVEL) : 48;
  localparam logic signed [TW-1:0] ONE_T  = TW'(64'h1_0000_0000);
  localparam logic signed [TW-1:0] HALF_T = TW'(64'h8000_0000);

  logic signed [34:0] xe, xl, gap;
  logic               edge_zero, err, mesh, zero;
  logic [13:0]        odd_j;
  logic signed [TW-1:0] xw, tw;
  logic [4:0]         nm1;
  logic signed [3:0]  ld;
  logic signed [9:0]  prod;
  logic [6:0]         expo;

  assign xe = $signed({2'b00, x_pos_i});

  always_comb begin
    xl        = xe;
    edge_zero = 1'b0;
    gap       = xe - 35'sh1_0000_0000;
    if (gap[34]) gap = -gap;
    case (side_e'(side_i))
      SIDE_LEFT: begin
        edge_zero = ({2'b00, x_pos_i} <= {19'b0, edge_epsilon_i});
        xl        = xe - $signed({19'b0, edge_epsilon_i});
      end
      SIDE_RIGHT: begin
        edge_zero = (gap <= $signed({19'b0, edge_epsilon_i}));
        xl        = xe + $signed({19'b0, edge_epsilon_i});
      end
      default: ;
    endcase
  end

  assign err = (degree_i > 3'd5) || (!poly_mode_i && degree_i > 3'd3) ||
               (poly_mode_i && deriv_order_i == 2'd3) || (level_i > 5'(MAX_LEVEL));

  assign odd_j = (support_index_i == '0) ? '0 : 14'((support_index_i - 15'd1) >> 1);
  assign xw    = {{(TW-35){xl[34]}}, xl};
  assign nm1   = level_i - 5'd1;

  always_comb begin
    if (level_i <= 5'd1) begin
      tw   = xw;
      mesh = level_i[0];
    end else begin
      tw   = (xw <<< nm1) - $signed({{(TW-46){1'b0}}, odd_j, 32'b0});
      mesh = 1'b1;
    end
  end

  // Level-1 halves: point-0 functions live up to one half, point-1 from one half.
  always_comb begin
    zero = edge_zero || tw[TW-1] || (tw > ONE_T);
    if (mesh && !degree_i[0] && (tw > HALF_T)) zero = 1'b1;
    if (mesh && degree_i[0] && (tw < HALF_T)) zero = 1'b1;
  end

  assign ld   = $signed({2'b00, degree_i[2:1]}) - $signed({2'b00, deriv_order_i});
  assign prod = $signed({1'b0, nm1}) * ld;
  assign expo = 7'(-prod);

  assign job_o.coef = poly_row(poly_mode_i, mesh, degree_i, deriv_order_i);
  assign job_o.t    = tw[32:0];
  assign job_o.expo = (err || level_i <= 5'd1) ? '0 : expo;
  assign job_o.err  = err;
  assign job_o.kill = err || zero;
endmodule

@@ hw/rtl/hwb_back.sv @@
// Back part: pipelined Horner evaluation in Q.32, rounding, saturation and output register.
module hwb_back #(
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hwb_pkg::job_t       job_i,
  input  logic                job_valid_i,
  output logic                job_pop_o,
  output logic signed [35:0]  value_o,
  output logic signed [6:0]   scale_exp_o,
  output logic                error_o,
  output logic                out_valid_o,
  input  logic                out_ready_i
);
  import hwb_pkg::*;

  localparam int NSTEP = NCOEF - 1;
  localparam int SH = 32 - OUT_FRAC_BITS;
  localparam logic signed [AW:0] RND = (SH > 0) ? (AW+1)'(64'd1 << (SH - 1)) : '0;
  localparam logic signed [AW:0] VMAX = (AW+1)'(64'h7_FFFF_FFFF);
  localparam logic signed [AW:0] VMIN = -(AW+1)'(64'h8_0000_0000);

  logic                 en;
  logic signed [AW-1:0] acc_q [NSTEP+1];
  job_t                 ja_q [NSTEP+1];
  logic                 va_q [NSTEP+1];
  logic signed [53:0]   pph_q [NSTEP];
  logic        [64:0]   ppl_q [NSTEP];
  job_t                 jm_q [NSTEP];
  logic                 vm_q [NSTEP];

  logic                 vout_q;
  logic signed [35:0]   val_q;
  logic signed [6:0]    exp_q;
  logic                 err_q;
  logic signed [AW:0]   rounded;
  logic signed [35:0]   val_d;

  // The whole pipe advances together whenever the output register can take a result.
  assign en        = !vout_q || out_ready_i;
  assign job_pop_o = en && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q[0] <= 1'b0;
    else if (en) va_q[0] <= job_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q[0] <= {{(AW-CW-31){job_i.coef[NCOEF-1][CW-1]}}, job_i.coef[NCOEF-1], 31'b0};
      ja_q[0]  <= job_i;
    end
  end

  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    logic [65:0]        lo_r;
    logic signed [55:0] sum;
    coef_t              ck;

    assign ck   = jm_q[s].coef[NSTEP-1-s];
    assign lo_r = {1'b0, ppl_q[s]} + 66'h8000_0000;
    assign sum  = {{2{pph_q[s][53]}}, pph_q[s]} + $signed({22'b0, lo_r[65:32]}) +
                  $signed({{(56-CW-31){ck[CW-1]}}, ck, 31'b0});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vm_q[s]   <= 1'b0;
        va_q[s+1] <= 1'b0;
      end else if (en) begin
        vm_q[s]   <= va_q[s];
        va_q[s+1] <= vm_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pph_q[s]   <= $signed(acc_q[s][AW-1:32]) * $signed({1'b0, ja_q[s].t});
        ppl_q[s]   <= acc_q[s][31:0] * ja_q[s].t;
        jm_q[s]    <= ja_q[s];
        acc_q[s+1] <= sum[AW-1:0];
        ja_q[s+1]  <= jm_q[s];
      end
    end
  end

  always_comb begin
    rounded = ($signed({acc_q[NSTEP][AW-1], acc_q[NSTEP]}) + RND) >>> SH;
    if (ja_q[NSTEP].kill)   val_d = '0;
    else if (rounded > VMAX) val_d = VMAX[35:0];
    else if (rounded < VMIN) val_d = VMIN[35:0];
    else                     val_d = rounded[35:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vout_q <= 1'b0;
    else if (en) vout_q <= va_q[NSTEP];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      exp_q <= ja_q[NSTEP].expo;
      err_q <= ja_q[NSTEP].err;
    end
  end

  assign value_o     = val_q;
  assign scale_exp_o = exp_q;
  assign error_o     = err_q;
  assign out_valid_o = vout_q;
endmodule

@@ hw/rtl/hwb_checker.sv @@
// Port-level checks of the basis evaluator and their attachment to the top level.
module hwb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  // A result held back by the sink must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // An unsupported request carries a zero mantissa and a zero exponent.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[43]) |-> (m_axis_tdata[42:0] == 43'd0))
    else $error("error result with non-zero fields");

  // No result is valid when reset has just been released.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // The padding bits above the error flag stay zero.
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:44] == 4'd0))
    else $error("padding bits set");
endmodule

bind hermite_wavelet_basis_eval hwb_checker u_hwb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
